@@ src/tsc_pkg.sv @@
// Package for the quadratic-spline particle weight pipeline.
// Request and result payload structs, and the fixed field widths.
// No dependencies.
package tsc_pkg;

    localparam int POS_BITS        = 32;
    localparam int SPACING_BITS    = 31;
    localparam int SLOT_FIELD_BITS = 16;
    localparam int W_BITS          = 20;

    typedef struct packed {
        logic signed [POS_BITS-1:0]     particle_pos_a;
        logic signed [POS_BITS-1:0]     particle_pos_b;
        logic signed [POS_BITS-1:0]     node_pos_a;
        logic signed [POS_BITS-1:0]     node_pos_b;
        logic        [SPACING_BITS-1:0] spacing_a;
        logic        [SPACING_BITS-1:0] spacing_b;
        logic [SLOT_FIELD_BITS-1:0]     particle_slot;
        logic                           cell_skip;
        logic                           last_particle;
    } particle_t;

    typedef struct packed {
        logic signed [W_BITS-1:0]   w_r0c0;
        logic signed [W_BITS-1:0]   w_r0c1;
        logic signed [W_BITS-1:0]   w_r0c2;
        logic signed [W_BITS-1:0]   w_r1c0;
        logic signed [W_BITS-1:0]   w_r1c1;
        logic signed [W_BITS-1:0]   w_r1c2;
        logic signed [W_BITS-1:0]   w_r2c0;
        logic signed [W_BITS-1:0]   w_r2c1;
        logic signed [W_BITS-1:0]   w_r2c2;
        logic [SLOT_FIELD_BITS-1:0] slot_out;
        logic                       weights_valid;
        logic                       last_out;
    } weight_t;

endpackage

@@ src/tsc_offset.sv @@
// Normalised offset (node - particle) / spacing, saturated to [-1, 1].
// Pipelined restoring divider, one quotient bit per stage; FRAC+4 stages.
// Depends on tsc_pkg.
module tsc_offset
    import tsc_pkg::*;
#(
    parameter int FRAC = 16
)
(
    input  logic                          clk,
    input  logic [FRAC+3:0]               en,
    input  logic signed [POS_BITS-1:0]    node,
    input  logic signed [POS_BITS-1:0]    part,
    input  logic [SPACING_BITS-1:0]       spacing,
    output logic signed [FRAC+1:0]        offset
);

    localparam logic [FRAC:0] ONE = {1'b1, {FRAC{1'b0}}};

    // stage 0: difference
    logic [POS_BITS:0]     diff_reg;
    logic [SPACING_BITS-1:0] sp0_reg;

    // stage 1: magnitude and sign
    logic [POS_BITS-1:0]   mag_reg;
    logic [POS_BITS:0]     diff_neg;
    logic                  neg1_reg;
    logic [SPACING_BITS-1:0] sp1_reg;

    // divider stages
    logic [SPACING_BITS-1:0] rem_reg  [FRAC+1];
    logic [FRAC:0]           quo_reg  [FRAC+1];
    logic [SPACING_BITS-1:0] sp_reg   [FRAC+1];
    logic                    neg_reg  [FRAC+1];
    logic                    sat_reg  [FRAC+1];
    logic                    zero_reg [FRAC+1];

    logic                    ge_first;
    logic [POS_BITS-1:0]     sub_first;

    logic signed [FRAC+1:0]  offset_reg;
    logic                    big;
    logic [FRAC:0]           mag_x;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            diff_reg <= {node[POS_BITS-1], node} - {part[POS_BITS-1], part};
            sp0_reg  <= spacing;
        end
    end

    assign diff_neg = -diff_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            mag_reg  <= diff_reg[POS_BITS] ? diff_neg[POS_BITS-1:0] : diff_reg[POS_BITS-1:0];
            neg1_reg <= diff_reg[POS_BITS];
            sp1_reg  <= sp0_reg;
        end
    end

    // Leading quotient bit; mag >= 2*sp means the quotient exceeds one anyway.
    assign ge_first  = mag_reg >= {1'b0, sp1_reg};
    assign sub_first = mag_reg - {1'b0, sp1_reg};

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            rem_reg[0]  <= ge_first ? sub_first[SPACING_BITS-1:0]
                                    : mag_reg[SPACING_BITS-1:0];
            quo_reg[0]  <= (FRAC+1)'(ge_first);
            sp_reg[0]   <= sp1_reg;
            neg_reg[0]  <= neg1_reg;
            sat_reg[0]  <= mag_reg >= {sp1_reg, 1'b0};
            zero_reg[0] <= mag_reg == '0;
        end
    end

    for (genvar j = 1; j <= FRAC; j++)
    begin : g_div
        logic [POS_BITS-1:0] r2;
        logic [POS_BITS-1:0] diff;
        logic                ge;

        assign r2   = {rem_reg[j-1], 1'b0};
        assign ge   = r2 >= {1'b0, sp_reg[j-1]};
        assign diff = r2 - {1'b0, sp_reg[j-1]};

        always_ff @(posedge clk)
        begin
            if (en[2+j])
            begin
                rem_reg[j]  <= ge ? diff[SPACING_BITS-1:0] : r2[SPACING_BITS-1:0];
                quo_reg[j]  <= {quo_reg[j-1][FRAC-1:0], ge};
                sp_reg[j]   <= sp_reg[j-1];
                neg_reg[j]  <= neg_reg[j-1];
                sat_reg[j]  <= sat_reg[j-1];
                zero_reg[j] <= zero_reg[j-1];
            end
        end
    end

    assign big = sat_reg[FRAC] || (quo_reg[FRAC][FRAC] && (|quo_reg[FRAC][FRAC-1:0]));

    always_comb
    begin
        if (zero_reg[FRAC])
            mag_x = '0;
        else if (big)
            mag_x = ONE;
        else
            mag_x = quo_reg[FRAC];
    end

    always_ff @(posedge clk)
    begin
        if (en[FRAC+3])
            offset_reg <= neg_reg[FRAC] ? -signed'({1'b0, mag_x}) : signed'({1'b0, mag_x});
    end

    assign offset = offset_reg;

endmodule

@@ src/tsc_weights.sv @@
// Spline weights from one saturated offset: side-low, middle, side-high.
// Three stages: shifted magnitudes, squares, middle weight.
// Depends on tsc_pkg.
module tsc_weights
    import tsc_pkg::*;
#(
    parameter int FRAC = 16
)
(
    input  logic                   clk,
    input  logic [2:0]             en,
    input  logic signed [FRAC+1:0] x,
    output logic signed [FRAC+1:0] lo,
    output logic signed [FRAC+1:0] mid,
    output logic signed [FRAC+1:0] hi
);

    localparam logic signed [FRAC+2:0] HALF = {3'b000, 1'b1, {(FRAC-1){1'b0}}};
    localparam logic signed [FRAC+1:0] ONE  = {2'b01, {FRAC{1'b0}}};

    logic signed [FRAC+2:0] x_ext;
    logic signed [FRAC+2:0] s_lo;
    logic signed [FRAC+2:0] s_hi;
    logic [FRAC+2:0]        n_lo;
    logic [FRAC+2:0]        n_hi;
    logic [FRAC:0]          mlo_reg;
    logic [FRAC:0]          mhi_reg;
    logic [2*FRAC+1:0]      sq_lo;
    logic [2*FRAC+1:0]      sq_hi;
    logic [FRAC:0]          qlo_reg;
    logic [FRAC:0]          qhi_reg;
    logic signed [FRAC+1:0] lo_reg;
    logic signed [FRAC+1:0] mid_reg;
    logic signed [FRAC+1:0] hi_reg;

    assign x_ext = (FRAC+3)'(x);
    assign s_lo  = HALF + x_ext;
    assign s_hi  = HALF - x_ext;
    assign n_lo  = -s_lo;
    assign n_hi  = -s_hi;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            mlo_reg <= s_lo[FRAC+2] ? n_lo[FRAC:0] : s_lo[FRAC:0];
            mhi_reg <= s_hi[FRAC+2] ? n_hi[FRAC:0] : s_hi[FRAC:0];
        end
    end

    assign sq_lo = mlo_reg * mlo_reg;
    assign sq_hi = mhi_reg * mhi_reg;

    // times 0.5 folded into the shift
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            qlo_reg <= sq_lo[2*FRAC+1:FRAC+1];
            qhi_reg <= sq_hi[2*FRAC+1:FRAC+1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            lo_reg  <= signed'({1'b0, qlo_reg});
            hi_reg  <= signed'({1'b0, qhi_reg});
            mid_reg <= ONE - signed'({1'b0, qlo_reg}) - signed'({1'b0, qhi_reg});
        end
    end

    assign lo  = lo_reg;
    assign mid = mid_reg;
    assign hi  = hi_reg;

endmodule

@@ src/tsc_particle_weights_2d.sv @@
// Quadratic-spline (TSC) weight pipeline: nine 2D weights per particle request.
// One request per cycle while the pipeline has room; it stalls only when full and the output is stalled.
// The depth is set by the offset divider, which resolves one quotient bit per stage.
// Bubbles close up, so requests are still taken while a result waits at the output.
// Reset clears the stage valid bits only; data registers are not reset.
module tsc_particle_weights_2d
    import tsc_pkg::*;
#(
    parameter int WEIGHT_FRAC_BITS = 16,
    parameter int SLOT_BITS        = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      particle_valid,
    output logic      particle_stall,
    input  particle_t particle,
    output logic      weight_valid,
    input  logic      weight_stall,
    output weight_t   weight
);

    localparam int FRAC = WEIGHT_FRAC_BITS;
    localparam int NOFF = FRAC + 4;
    localparam int NST  = FRAC + 9;
    localparam int SB   = (SLOT_BITS < SLOT_FIELD_BITS) ? SLOT_BITS : SLOT_FIELD_BITS;
    localparam int PW   = 2*FRAC + 4;

    localparam logic signed [PW-1:0] W_HI = {{(PW-W_BITS+1){1'b0}}, {(W_BITS-1){1'b1}}};
    localparam logic signed [PW-1:0] W_LO = {{(PW-W_BITS+1){1'b1}}, {(W_BITS-1){1'b0}}};
    localparam logic signed [FRAC+3:0] ONE_SUM = {4'b0001, {FRAC{1'b0}}};

    logic [NST-1:0]  valid_reg;
    logic [NST-1:0]  ld;
    logic [SB-1:0]   slot_reg [NST];
    logic            skip_reg [NST];
    logic            last_reg [NST];

    logic signed [FRAC+1:0] xa;
    logic signed [FRAC+1:0] xb;
    logic signed [FRAC+1:0] wa [3];
    logic signed [FRAC+1:0] wb [3];

    logic signed [PW-1:0]     prod_reg [9];
    logic signed [PW-1:0]     shifted  [9];
    logic signed [W_BITS-1:0] sat_w    [9];
    logic signed [W_BITS-1:0] wout_reg [9];

    // A stage loads when it is empty or its contents move on.
    always_comb
    begin
        ld[NST-1] = !valid_reg[NST-1] || !weight_stall;
        for (int k = NST-2; k >= 0; k--)
            ld[k] = !valid_reg[k] || ld[k+1];
    end

    assign particle_stall = !ld[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (ld[0])
                valid_reg[0] <= particle_valid;
            for (int k = 1; k < NST; k++)
                if (ld[k])
                    valid_reg[k] <= valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            slot_reg[0] <= particle.particle_slot[SB-1:0];
            skip_reg[0] <= particle.cell_skip;
            last_reg[0] <= particle.last_particle;
        end
        for (int k = 1; k < NST; k++)
            if (ld[k])
            begin
                slot_reg[k] <= slot_reg[k-1];
                skip_reg[k] <= skip_reg[k-1];
                last_reg[k] <= last_reg[k-1];
            end
    end

    tsc_offset #(.FRAC(FRAC)) u_offset_a
    (
        .clk     (clk),
        .en      (ld[NOFF-1:0]),
        .node    (particle.node_pos_a),
        .part    (particle.particle_pos_a),
        .spacing (particle.spacing_a),
        .offset  (xa)
    );

    tsc_offset #(.FRAC(FRAC)) u_offset_b
    (
        .clk     (clk),
        .en      (ld[NOFF-1:0]),
        .node    (particle.node_pos_b),
        .part    (particle.particle_pos_b),
        .spacing (particle.spacing_b),
        .offset  (xb)
    );

    tsc_weights #(.FRAC(FRAC)) u_weights_a
    (
        .clk (clk),
        .en  (ld[NOFF+2:NOFF]),
        .x   (xa),
        .lo  (wa[0]),
        .mid (wa[1]),
        .hi  (wa[2])
    );

    tsc_weights #(.FRAC(FRAC)) u_weights_b
    (
        .clk (clk),
        .en  (ld[NOFF+2:NOFF]),
        .x   (xb),
        .lo  (wb[0]),
        .mid (wb[1]),
        .hi  (wb[2])
    );

    // row weight from b, column weight from a
    always_ff @(posedge clk)
    begin
        if (ld[NOFF+3])
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    prod_reg[r*3+c] <= PW'(wb[r] * wa[c]);
        end
    end

    // arithmetic shift is the floor, then clamp to the 20-bit field
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            shifted[i] = prod_reg[i] >>> FRAC;
            if (shifted[i] > W_HI)
                sat_w[i] = W_HI[W_BITS-1:0];
            else if (shifted[i] < W_LO)
                sat_w[i] = W_LO[W_BITS-1:0];
            else
                sat_w[i] = shifted[i][W_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[NST-1])
        begin
            for (int i = 0; i < 9; i++)
                wout_reg[i] <= skip_reg[NST-2] ? '0 : sat_w[i];
        end
    end

    assign weight_valid         = valid_reg[NST-1];
    assign weight.w_r0c0        = wout_reg[0];
    assign weight.w_r0c1        = wout_reg[1];
    assign weight.w_r0c2        = wout_reg[2];
    assign weight.w_r1c0        = wout_reg[3];
    assign weight.w_r1c1        = wout_reg[4];
    assign weight.w_r1c2        = wout_reg[5];
    assign weight.w_r2c0        = wout_reg[6];
    assign weight.w_r2c1        = wout_reg[7];
    assign weight.w_r2c2        = wout_reg[8];
    assign weight.slot_out      = SLOT_FIELD_BITS'(slot_reg[NST-1]);
    assign weight.weights_valid = !skip_reg[NST-1];
    assign weight.last_out      = last_reg[NST-1];

    // the three weights of one direction always sum to one
    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NOFF+2] && !skip_reg[NOFF+2] |->
            (FRAC+4)'(wa[0]) + (FRAC+4)'(wa[1]) + (FRAC+4)'(wa[2]) == ONE_SUM)
        else $error("a-direction weights do not sum to one");

    a_side_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NOFF+2] |-> !wb[0][FRAC+1] && !wb[2][FRAC+1])
        else $error("negative side weight");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        particle_stall |-> (&valid_reg) && weight_stall)
        else $error("request stalled with room in the pipeline");

    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        weight_valid && !weight.weights_valid |->
            weight.w_r0c0 == '0 && weight.w_r1c1 == '0 && weight.w_r2c2 == '0)
        else $error("skipped request carries nonzero weights");

endmodule
